// ----- hw/rtl/bopa_pkg.sv -----
// Shared types, constants and codes for the bitmap object pool allocator.
package bopa_pkg;

   localparam int MAX_NODES  = 64;
   localparam int ADDR_WIDTH = 32;

   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 16;
   localparam int COUNT_W  = 7;
   localparam int IDX_W    = 6;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int NODE_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int MUL_W    = COUNT_W + SIZE_W;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_CNT_W = $clog2(ADDR_W);

   localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ADDR_WIDTH >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_INIT  = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              addr_zero;
      logic [ADDR_W-1:0] addr;
   } item_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  base;
      logic [SIZE_W-1:0]  size;
      logic [COUNT_W-1:0] count;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] dividend;
      logic [SIZE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] quotient;
      logic [SIZE_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ----- hw/rtl/bopa_front.sv -----
// Request intake: accept a transaction, decode the function and stage it for the queue.
module bopa_front import bopa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [FUNC_W-1:0] in_func,
   input  logic [ADDR_W-1:0] in_addr,
   output logic              push_valid,
   input  logic              push_ready,
   output item_type          push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   kind_type kind;

   always_comb begin
      case (in_func)
         FUNC_ALLOC: kind = KIND_ALLOC;
         FUNC_FREE:  kind = KIND_FREE;
         FUNC_INIT:  kind = KIND_INIT;
         default:    kind = KIND_NOP;
      endcase
   end

   assign in_ready   = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push_ready) begin
         valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         valid_in          = 1'b1;
         item_in.kind      = kind;
         item_in.addr      = in_addr;
         item_in.addr_zero = (in_addr == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ----- hw/rtl/bopa_queue.sv -----
// Two-entry queue between request intake and the execution sequencer.
module bopa_queue import bopa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop,
   output item_type pop_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/bopa_div.sv -----
// Restoring divider, one quotient bit per cycle, for the free address alignment check.
module bopa_div import bopa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;
   logic [ADDR_W-1:0]    quo_ff, quo_in;
   logic [SIZE_W-1:0]    div_ff, div_in;
   logic [SIZE_W:0]      trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[ADDR_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         div_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? SIZE_W'(trial - {1'b0, div_ff}) : trial[SIZE_W-1:0];
         quo_in = {quo_ff[ADDR_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(ADDR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ----- hw/rtl/bopa_back.sv -----
// Execution sequencer: free bitmap, allocate/free/init handling and the result register.
module bopa_back import bopa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                q_valid,
   output logic                q_pop,
   input  item_type            q_item,
   output div_req_type         div_req,
   input  div_rsp_type         div_rsp,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [STATUS_W-1:0] out_status,
   output logic [IDX_W-1:0]    out_index,
   output logic [ADDR_W-1:0]   out_addr
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CALC = 5'b00010,
      ST_EVAL = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   item_type               item_ff, item_in;
   logic [MAX_NODES-1:0]   map_ff, map_in;
   logic [NODE_W-1:0]      pick_ff, pick_in;
   logic                   found_ff, found_in;
   logic [MUL_W-1:0]       mul_ff, mul_in;
   status_type             res_status_ff, res_status_in;
   logic [IDX_W-1:0]       res_index_ff, res_index_in;
   logic [ADDR_W-1:0]      res_addr_ff, res_addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;

   logic [COUNT_W-1:0]     live;
   logic [MAX_NODES-1:0]   init_mask;
   logic [NODE_W-1:0]      low_free;
   logic [COUNT_W-1:0]     mul_a;
   logic [ADDR_W:0]        end_addr;
   logic                   bad_free;
   logic [NODE_W-1:0]      quo_node;

   assign live = (cfg.count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : cfg.count;

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         init_mask[i] = (COUNT_W'(i) < live);
      end
   end

   always_comb begin
      low_free = '0;
      for (int i = MAX_NODES - 1; i >= 0; i--) begin
         if (map_ff[i]) begin
            low_free = NODE_W'(i);
         end
      end
   end

   assign mul_a    = (item_ff.kind == KIND_ALLOC) ? COUNT_W'(low_free) : live;
   assign end_addr = {1'b0, cfg.base} + (ADDR_W + 1)'(mul_ff);
   assign bad_free = item_ff.addr_zero || (cfg.size == '0) || (item_ff.addr < cfg.base)
                     || ({1'b0, item_ff.addr} >= end_addr);
   assign quo_node = div_rsp.quotient[NODE_W-1:0];

   assign q_pop            = (state_ff == ST_IDLE) && q_valid;
   assign div_req.start    = (state_ff == ST_EVAL) && (item_ff.kind == KIND_FREE) && !bad_free;
   assign div_req.dividend = item_ff.addr - cfg.base;
   assign div_req.divisor  = cfg.size;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      map_in        = map_ff;
      pick_in       = pick_ff;
      found_in      = found_ff;
      mul_in        = mul_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_addr_in   = rsp_addr_ff;
      if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               item_in  = q_item;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            pick_in  = low_free;
            found_in = |map_ff;
            mul_in   = MUL_W'(mul_a * cfg.size);
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            res_status_in = STATUS_OK;
            res_index_in  = '0;
            res_addr_in   = '0;
            state_in      = ST_FIN;
            case (item_ff.kind)
               KIND_ALLOC: begin
                  if (found_ff) begin
                     map_in[pick_ff] = 1'b0;
                     res_index_in    = IDX_W'(pick_ff);
                     res_addr_in     = (cfg.base + ADDR_W'(mul_ff)) & ADDR_MASK;
                  end else begin
                     res_status_in = STATUS_EMPTY;
                  end
               end
               KIND_FREE: begin
                  if (bad_free) begin
                     res_status_in = STATUS_INVALID;
                  end else begin
                     state_in = ST_DIV;
                  end
               end
               KIND_INIT: begin
                  map_in = init_mask;
               end
               default: begin
               end
            endcase
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder != '0) begin
                  res_status_in = STATUS_INVALID;
               end else begin
                  map_in[quo_node] = 1'b1;
                  res_index_in     = div_rsp.quotient[IDX_W-1:0];
               end
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || out_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_ff       <= map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      pick_ff       <= pick_in;
      found_ff      <= found_in;
      mul_ff        <= mul_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign out_valid  = rsp_valid_ff;
   assign out_status = rsp_status_ff;
   assign out_index  = rsp_index_ff;
   assign out_addr   = rsp_addr_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_div_start_eval: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> state_ff == ST_EVAL)
      else $error("divider started outside evaluation");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished while sequencer not waiting");

   a_alloc_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && item_ff.kind == KIND_ALLOC && found_ff)
      |=> !map_ff[$past(pick_ff)])
      else $error("allocated node still marked free");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == ST_CALC)
      else $error("queue pop did not start execution");

endmodule

// ----- hw/rtl/bitmap_object_pool_allocator_core.sv -----
// Top level of the bitmap object pool allocator: CSRs, intake, queue, sequencer, divider.
// Sequence: allocate, init and unused codes go from queue head via CALC, EVAL and FIN to the
// result register; free adds DIV if the address passes the bounds check (32-step divider).
// Throughput: one transaction at a time in the sequencer; intake and a two-entry queue keep
// accepting up to three transactions ahead while a result waits on rsp_tready.
// Reset: synchronous, active high; empties queue and result register, marks no node free,
// and sets base address 0, node size 1 and node count 0.
module bitmap_object_pool_allocator_core import bopa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [39:0]          req_tdata,   // [31:0] node_address, [39:32] zero
   input  logic [FUNC_W-1:0]    req_tuser,   // [1:0] func
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // [5:0] node_index, [37:6] result_address
   output logic [STATUS_W-1:0]  rsp_tuser,   // [1:0] status
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   logic [ADDR_W-1:0]  base_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [COUNT_W-1:0] count_ff;
   cfg_type            cfg;

   logic        push_valid, push_ready, q_valid, q_pop;
   item_type    push_item, q_item;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic [IDX_W-1:0]  out_index;
   logic [ADDR_W-1:0] out_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         size_ff  <= SIZE_W'(1);
         count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE:  base_ff  <= csr_wdata;
            CSR_SIZE:  size_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.base  = base_ff;
   assign cfg.size  = size_ff;
   assign cfg.count = count_ff;

   bopa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_func    (req_tuser),
      .in_addr    (req_tdata[ADDR_W-1:0]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   bopa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   bopa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   bopa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (rsp_tuser),
      .out_index  (out_index),
      .out_addr   (out_addr)
   );

   assign rsp_tdata = {2'b00, out_addr, out_index};

endmodule
